@@ sv/alle_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the array linked list engine.
// No dependencies; imported by every module of the block.
package alle_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int VALUE_BITS_DEF = 24;

	localparam int OPCODE_W   = 3;
	localparam int ITEM_W     = 24;
	localparam int POS_W      = 5;
	localparam int STATUS_W   = 3;
	localparam int FOUND_W    = 5;
	localparam int SLOT_OUT_W = 4;
	localparam int PTR_W      = 5;
	localparam int COUNT_W    = 5;

	localparam logic [OPCODE_W-1:0] OP_INIT   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_INIT  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_WLOAD,
		ST_WALK,
		ST_LINK1,
		ST_LINK2,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic val_we;
		logic next_we;
	} store_ctl_t;

endpackage

@@ sv/array_linked_list_engine.sv @@
`timescale 1ns / 1ps
// Linked list engine over fixed slot memories: init, append, insert, delete, find.
// Depends on alle_pkg and alle_store.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid, in_stall | opcode, item_value, position
//  out     | source    | out_valid, out_stall | status, found_position, slot_used,
//          |           |                    | head_slot, tail_slot, item_count
//
// Init, errors and unused opcodes go from decode straight to the result.
// Append/insert add a free-slot search upward from slot 0. A mid-list insert, a delete
// of more than one item and find load the head, then walk the next-link memory one link
// a cycle (up to LIST_DEPTH links), then up to two link updates (delete: read, write).
// Reset clears occupancy, count and control; the slot memories are not cleared.
// A finished result waits in the output register; the next input transfer is taken.
module array_linked_list_engine #(
	parameter int LIST_DEPTH = alle_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [alle_pkg::OPCODE_W-1:0]      opcode,
	input  logic [alle_pkg::ITEM_W-1:0]        item_value,
	input  logic [alle_pkg::POS_W-1:0]         position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [alle_pkg::STATUS_W-1:0]      status,
	output logic [alle_pkg::FOUND_W-1:0]       found_position,
	output logic [alle_pkg::SLOT_OUT_W-1:0]    slot_used,
	output logic signed [alle_pkg::PTR_W-1:0]  head_slot,
	output logic signed [alle_pkg::PTR_W-1:0]  tail_slot,
	output logic [alle_pkg::COUNT_W-1:0]       item_count
);
	import alle_pkg::*;

	localparam int SLOT_W = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	state_t state_q, state_d;

	logic [OPCODE_W-1:0]   op_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	logic [CMP_W-1:0]      ins_pos_q;
	logic [CNT_W-1:0]      target_q;
	logic [CNT_W-1:0]      walk_k_q;
	logic [SLOT_W-1:0]     walk_slot_q;
	logic [SLOT_W-1:0]     scan_q;
	logic [SLOT_W-1:0]     free_q;
	logic [SLOT_W-1:0]     prev_q;
	logic [SLOT_W-1:0]     prev_next_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     head_q;
	logic [SLOT_W-1:0]     tail_q;
	logic [CNT_W-1:0]      found_q;
	logic [STATUS_W-1:0]   status_q;

	logic [CNT_W-1:0]      count_q;
	logic                  init_q;
	logic [LIST_DEPTH-1:0] occ_q;
	logic                  out_valid_q;

	logic [STATUS_W-1:0]      out_status_q;
	logic [FOUND_W-1:0]       out_found_q;
	logic [SLOT_OUT_W-1:0]    out_slot_q;
	logic [PTR_W-1:0]         out_head_q;
	logic [PTR_W-1:0]         out_tail_q;
	logic [COUNT_W-1:0]       out_count_q;

	store_ctl_t            st_ctl;
	logic [SLOT_W-1:0]     st_waddr;
	logic [SLOT_W-1:0]     st_wnext;
	logic [SLOT_W-1:0]     st_raddr;
	logic [VALUE_BITS-1:0] rd_value;
	logic [SLOT_W-1:0]     rd_next;

	logic [CMP_W-1:0]    pos_c;
	logic [CMP_W-1:0]    cnt_c;
	logic                is_full;
	logic                is_empty;
	logic                ins_bad;
	logic                del_bad;
	logic                p_first;
	logic                p_last;
	logic                del_last;
	logic                at_target;
	logic                at_end;
	logic                val_hit;
	logic                free_hit;
	logic                direct_link;
	logic [STATUS_W-1:0] dec_status;
	logic                dec_scan;
	logic                dec_walk;
	logic                dec_single;
	logic                out_load;
	logic [31:0]         slot_ext;
	logic [31:0]         head_ext;
	logic [31:0]         tail_ext;
	logic [31:0]         found_ext;
	logic [31:0]         count_ext;

	alle_store #(
		.LIST_DEPTH (LIST_DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.SLOT_W     (SLOT_W)
	) u_store (
		.clk    (clk),
		.ctl    (st_ctl),
		.waddr  (st_waddr),
		.wvalue (val_q),
		.wnext  (st_wnext),
		.raddr  (st_raddr),
		.rvalue (rd_value),
		.rnext  (rd_next)
	);

	assign pos_c       = CMP_W'(pos_q);
	assign cnt_c       = CMP_W'(count_q);
	assign is_full     = (count_q == CNT_W'(LIST_DEPTH));
	assign is_empty    = (count_q == '0);
	assign ins_bad     = (pos_q == '0) || (pos_c > cnt_c + CMP_W'(1));
	assign del_bad     = (pos_q == '0) || (pos_c > cnt_c);
	assign p_first     = (ins_pos_q == CMP_W'(1));
	assign p_last      = (ins_pos_q == cnt_c + CMP_W'(1));
	assign del_last    = (pos_c == cnt_c);
	assign at_target   = (walk_k_q == target_q);
	assign at_end      = (walk_k_q == count_q);
	assign val_hit     = (rd_value == val_q);
	assign free_hit    = !occ_q[scan_q];
	assign direct_link = is_empty || p_first || p_last;

	always_comb begin
		dec_status = STAT_OK;
		dec_scan   = 1'b0;
		dec_walk   = 1'b0;
		dec_single = 1'b0;
		case (op_q)
			OP_INIT: begin
				dec_status = STAT_OK;
			end
			OP_APPEND, OP_INSERT: begin
				if (!init_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (is_full) begin
					dec_status = STAT_FULL;
				end else if (op_q == OP_INSERT && ins_bad) begin
					dec_status = STAT_INVALID;
				end else begin
					dec_scan = 1'b1;
				end
			end
			OP_DELETE: begin
				if (!init_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (is_empty) begin
					dec_status = STAT_EMPTY;
				end else if (del_bad) begin
					dec_status = STAT_INVALID;
				end else if (count_q == CNT_W'(1)) begin
					dec_single = 1'b1;
				end else begin
					dec_walk = 1'b1;
				end
			end
			OP_FIND: begin
				if (!init_q) begin
					dec_status = STAT_NOT_INIT;
				end else if (is_empty) begin
					dec_status = STAT_NOT_FOUND;
				end else begin
					dec_walk = 1'b1;
				end
			end
			default: begin
				dec_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (dec_scan) begin
					state_d = ST_SCAN;
				end else if (dec_walk) begin
					state_d = ST_WLOAD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (free_hit) begin
					state_d = direct_link ? ST_LINK1 : ST_WLOAD;
				end
			end
			ST_WLOAD: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (op_q == OP_FIND) begin
					if (val_hit || at_end) begin
						state_d = ST_DONE;
					end
				end else if (at_target) begin
					if (op_q == OP_DELETE) begin
						state_d = (pos_q == POS_W'(1)) ? ST_DONE : ST_DEL_RD;
					end else begin
						state_d = ST_LINK1;
					end
				end
			end
			ST_LINK1: begin
				state_d = (is_empty || p_first) ? ST_DONE : ST_LINK2;
			end
			ST_LINK2: begin
				state_d = ST_DONE;
			end
			ST_DEL_RD: begin
				state_d = ST_DEL_WR;
			end
			ST_DEL_WR: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		st_ctl   = '0;
		st_waddr = free_q;
		st_wnext = '0;
		st_raddr = head_q;
		case (state_q)
			ST_WALK: begin
				st_raddr = rd_next;
			end
			ST_DEL_RD: begin
				st_raddr = slot_q;
			end
			ST_LINK1: begin
				st_ctl.val_we  = 1'b1;
				st_ctl.next_we = 1'b1;
				st_waddr       = free_q;
				if (is_empty || p_last) begin
					st_wnext = '0;
				end else if (p_first) begin
					st_wnext = head_q;
				end else begin
					st_wnext = prev_next_q;
				end
			end
			ST_LINK2: begin
				st_ctl.next_we = 1'b1;
				st_waddr       = p_last ? tail_q : prev_q;
				st_wnext       = free_q;
			end
			ST_DEL_WR: begin
				st_ctl.next_we = 1'b1;
				st_waddr       = prev_q;
				st_wnext       = del_last ? '0 : rd_next;
			end
			default: begin
				st_raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			init_q      <= 1'b0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DECODE: begin
					if (op_q == OP_INIT) begin
						occ_q   <= '0;
						count_q <= '0;
						init_q  <= 1'b1;
					end else if (dec_single) begin
						occ_q[head_q] <= 1'b0;
						count_q       <= '0;
					end
				end
				ST_WALK: begin
					if (op_q == OP_DELETE && at_target && pos_q == POS_W'(1)) begin
						occ_q[walk_slot_q] <= 1'b0;
						count_q            <= count_q - CNT_W'(1);
					end
				end
				ST_LINK1: begin
					occ_q[free_q] <= 1'b1;
					if (is_empty || p_first) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_LINK2: begin
					count_q <= count_q + CNT_W'(1);
				end
				ST_DEL_WR: begin
					occ_q[slot_q] <= 1'b0;
					count_q       <= count_q - CNT_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign slot_ext  = 32'(slot_q);
	assign head_ext  = 32'(head_q);
	assign tail_ext  = 32'(tail_q);
	assign found_ext = 32'(found_q);
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q  <= opcode;
					val_q <= VALUE_BITS'(item_value);
					pos_q <= position;
				end
			end
			ST_DECODE: begin
				status_q  <= dec_status;
				found_q   <= '0;
				slot_q    <= dec_single ? head_q : '0;
				scan_q    <= '0;
				ins_pos_q <= (op_q == OP_APPEND) ? cnt_c + CMP_W'(1) : pos_c;
				target_q  <= (pos_q == POS_W'(1)) ? CNT_W'(1) : CNT_W'(pos_c - CMP_W'(1));
			end
			ST_SCAN: begin
				if (free_hit) begin
					free_q   <= scan_q;
					slot_q   <= scan_q;
					target_q <= CNT_W'(ins_pos_q - CMP_W'(1));
				end else begin
					scan_q <= scan_q + SLOT_W'(1);
				end
			end
			ST_WLOAD: begin
				walk_slot_q <= head_q;
				walk_k_q    <= CNT_W'(1);
			end
			ST_WALK: begin
				if (op_q == OP_FIND) begin
					if (val_hit) begin
						found_q <= walk_k_q;
					end else if (at_end) begin
						status_q <= STAT_NOT_FOUND;
					end
				end else if (at_target) begin
					if (op_q == OP_DELETE && pos_q == POS_W'(1)) begin
						slot_q <= walk_slot_q;
						head_q <= rd_next;
					end else if (op_q == OP_DELETE) begin
						prev_q <= walk_slot_q;
						slot_q <= rd_next;
					end else begin
						prev_q      <= walk_slot_q;
						prev_next_q <= rd_next;
					end
				end
				walk_slot_q <= rd_next;
				walk_k_q    <= walk_k_q + CNT_W'(1);
			end
			ST_LINK1: begin
				if (is_empty) begin
					head_q <= free_q;
					tail_q <= free_q;
				end else if (p_first) begin
					head_q <= free_q;
				end
			end
			ST_LINK2: begin
				if (p_last) begin
					tail_q <= free_q;
				end
			end
			ST_DEL_WR: begin
				if (del_last) begin
					tail_q <= prev_q;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_status_q <= status_q;
					out_found_q  <= found_ext[FOUND_W-1:0];
					out_slot_q   <= slot_ext[SLOT_OUT_W-1:0];
					out_head_q   <= is_empty ? '1 : head_ext[PTR_W-1:0];
					out_tail_q   <= is_empty ? '1 : tail_ext[PTR_W-1:0];
					out_count_q  <= count_ext[COUNT_W-1:0];
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found_position = out_found_q;
	assign slot_used      = out_slot_q;
	assign head_slot      = out_head_q;
	assign tail_slot      = out_tail_q;
	assign item_count     = out_count_q;

endmodule

@@ sv/alle_store.sv @@
`timescale 1ns / 1ps
// Value and next-link memories of the list, one write and one read port each.
// Depends on alle_pkg for the write control struct.
module alle_store #(
	parameter int LIST_DEPTH = alle_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF,
	parameter int SLOT_W     = $clog2(LIST_DEPTH)
) (
	input  logic                  clk,
	input  alle_pkg::store_ctl_t  ctl,
	input  logic [SLOT_W-1:0]     waddr,
	input  logic [VALUE_BITS-1:0] wvalue,
	input  logic [SLOT_W-1:0]     wnext,
	input  logic [SLOT_W-1:0]     raddr,
	output logic [VALUE_BITS-1:0] rvalue,
	output logic [SLOT_W-1:0]     rnext
);
	import alle_pkg::*;

	logic [VALUE_BITS-1:0] value_mem [LIST_DEPTH];
	logic [SLOT_W-1:0]     next_mem  [LIST_DEPTH];
	logic [VALUE_BITS-1:0] rvalue_s1;
	logic [SLOT_W-1:0]     rnext_s1;

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			value_mem[waddr] <= wvalue;
		end
		if (ctl.next_we) begin
			next_mem[waddr] <= wnext;
		end
		rvalue_s1 <= value_mem[raddr];
		rnext_s1  <= next_mem[raddr];
	end

	assign rvalue = rvalue_s1;
	assign rnext  = rnext_s1;

endmodule

@@ sv/alle_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the array linked list engine, bound to the top level.
// Depends on alle_pkg for status codes.
module alle_checker #(
	parameter int LIST_DEPTH = alle_pkg::LIST_DEPTH_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [alle_pkg::OPCODE_W-1:0]      opcode,
	input logic [alle_pkg::ITEM_W-1:0]        item_value,
	input logic [alle_pkg::POS_W-1:0]         position,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [alle_pkg::STATUS_W-1:0]      status,
	input logic [alle_pkg::FOUND_W-1:0]       found_position,
	input logic [alle_pkg::SLOT_OUT_W-1:0]    slot_used,
	input logic signed [alle_pkg::PTR_W-1:0]  head_slot,
	input logic signed [alle_pkg::PTR_W-1:0]  tail_slot,
	input logic [alle_pkg::COUNT_W-1:0]       item_count
);
	import alle_pkg::*;

	// hold a stalled input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(item_value)
			&& $stable(position))
		else $error("stalled input changed");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(item_count)
			&& $stable(head_slot) && $stable(tail_slot) && $stable(found_position)
			&& $stable(slot_used))
		else $error("stalled result changed");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_position != '0 |-> status == STAT_OK)
		else $error("found position with failing status");

	a_not_init_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_NOT_INIT |->
			item_count == '0 && head_slot == -5'sd1 && tail_slot == -5'sd1)
		else $error("list not empty before init");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> item_count == COUNT_W'(LIST_DEPTH))
		else $error("full reported below depth");

endmodule

bind array_linked_list_engine alle_checker #(.LIST_DEPTH(LIST_DEPTH)) u_alle_checker (.*);
